// ----- rtl/sat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants of the summed-area table core
// Field widths, status and operation codes, controller states and the
// command and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sat_pkg;

  // Fixed field widths.
  localparam int unsigned SUM_W     = 34;
  localparam int unsigned ELEM_W    = 18;
  localparam int unsigned COORD_W   = 8;
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned CFG_IDX_W = 1;

  // Default table bounds and size register reset value.
  localparam int unsigned MAX_ROWS_DEF = 256;
  localparam int unsigned MAX_COLS_DEF = 256;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RECT  = 2'd1,
    ST_NOT_READY = 2'd2
  } status_e;

  // Corners of a query rectangle, in the order they are read.
  typedef enum logic [1:0] {
    CORNER_A = 2'd0, // bottom-right, added
    CORNER_B = 2'd1, // above the top edge, subtracted
    CORNER_C = 2'd2, // left of the left edge, subtracted
    CORNER_D = 2'd3  // above and to the left, added
  } corner_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_Q0,
    S_Q1,
    S_Q2,
    S_Q3,
    S_Q4,
    S_HOLD
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_stall;
    logic    accept_load;
    logic    accept_query;
    logic    ld_read;
    logic    ld_write;
    logic    q_read;
    corner_e rd_corner;
    logic    acc_en;
    corner_e acc_corner;
    logic    out_push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic query_err;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- rtl/sat_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sat_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_datapath: table memory, load counters, query accumulator, output register
// Executes the controller's commands: builds prefix entries during loads and
// combines four corner reads into a region sum during queries.
// ----------------------------------------------------------------------------
module sat_datapath #(
  parameter int unsigned MAX_ROWS = sat_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = sat_pkg::MAX_COLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [sat_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sat_pkg::SIZE_W-1:0]         cfg_data_i,
  input  logic signed [sat_pkg::ELEM_W-1:0]  element_value_i,
  input  logic [sat_pkg::COORD_W-1:0]        top_row_i,
  input  logic [sat_pkg::COORD_W-1:0]        left_col_i,
  input  logic [sat_pkg::COORD_W-1:0]        bottom_row_i,
  input  logic [sat_pkg::COORD_W-1:0]        right_col_i,
  input  sat_pkg::cmd_t                      cmd_i,
  output sat_pkg::dp_status_t                dp_status_o,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic signed [sat_pkg::SUM_W-1:0]   region_sum_o,
  output logic [1:0]                         result_status_o
);

  localparam int unsigned SZ     = sat_pkg::SIZE_W;
  localparam int unsigned SW     = sat_pkg::SUM_W;
  localparam int unsigned EW     = sat_pkg::ELEM_W;
  localparam int unsigned CW     = sat_pkg::COORD_W;
  // Largest size a 9-bit register can select after clamping.
  localparam int unsigned SizeMax = (1 << SZ) - 1;
  localparam int unsigned RowLim = (MAX_ROWS < SizeMax) ? MAX_ROWS : SizeMax;
  localparam int unsigned ColLim = (MAX_COLS < SizeMax) ? MAX_COLS : SizeMax;
  localparam int unsigned RowIdxW = (RowLim > 1) ? $clog2(RowLim) : 1;
  localparam int unsigned ColIdxW = (ColLim > 1) ? $clog2(ColLim) : 1;
  localparam int unsigned SzRW = $clog2(RowLim + 1);
  localparam int unsigned SzCW = $clog2(ColLim + 1);
  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ProdW = AddrW + SZ;

  // Table address of a row and column.
  function automatic logic [AddrW-1:0] tab_addr(input logic [SZ-1:0] row,
                                                input logic [SZ-1:0] col);
    logic [ProdW-1:0] p;
    p = ProdW'(row) * ProdW'(MAX_COLS) + ProdW'(col);
    return p[AddrW-1:0];
  endfunction

  // Configuration and load state.
  logic [SZ-1:0]      rows_q, rows_d, cols_q, cols_d;
  logic [RowIdxW-1:0] load_row_q, load_row_d;
  logic [ColIdxW-1:0] load_col_q, load_col_d;
  logic [SW-1:0]      row_sum_q, row_sum_d;
  logic               ready_q, ready_d;
  logic               out_valid_q, out_valid_d;

  // Item and result payload.
  logic signed [EW-1:0] elem_q;
  logic [CW-1:0]        top_q, left_q, bottom_q, right_q;
  sat_pkg::status_e     status_q, status_d;
  logic [SW-1:0]        acc_q, acc_d;
  logic [SW-1:0]        out_sum_q;
  sat_pkg::status_e     out_status_q;

  logic [SzRW-1:0]  rows_eff;
  logic [SzCW-1:0]  cols_eff;
  logic             col_last, row_last;
  logic [SW-1:0]    elem_ext;
  logic [SW-1:0]    rd_data, wr_data, acc_val;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             rd_en;
  logic [SZ-1:0]    q_row, q_col;
  logic             rd_zero, acc_zero;

  // Clamp the size registers into the usable range.
  always_comb begin
    if (rows_q == '0) begin
      rows_eff = SzRW'(1);
    end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
      rows_eff = SzRW'(MAX_ROWS);
    end else begin
      rows_eff = SzRW'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = SzCW'(1);
    end else if (32'(cols_q) > 32'(MAX_COLS)) begin
      cols_eff = SzCW'(MAX_COLS);
    end else begin
      cols_eff = SzCW'(cols_q);
    end
  end

  // Query check on the incoming item.
  always_comb begin
    if (!ready_q) begin
      status_d = sat_pkg::ST_NOT_READY;
    end else if ((top_row_i > bottom_row_i) || (left_col_i > right_col_i) ||
                 (SZ'(bottom_row_i) >= SZ'(rows_eff)) ||
                 (SZ'(right_col_i) >= SZ'(cols_eff))) begin
      status_d = sat_pkg::ST_BAD_RECT;
    end else begin
      status_d = sat_pkg::ST_OK;
    end
  end

  assign elem_ext = {{(SW - EW){elem_q[EW-1]}}, elem_q};
  assign col_last = (SzCW'(load_col_q) + SzCW'(1)) == cols_eff;
  assign row_last = (SzRW'(load_row_q) + SzRW'(1)) == rows_eff;

  // Corner coordinates and border flags for a query read.
  always_comb begin
    unique case (cmd_i.rd_corner)
      sat_pkg::CORNER_A: begin
        q_row   = SZ'(bottom_q);
        q_col   = SZ'(right_q);
        rd_zero = 1'b0;
      end
      sat_pkg::CORNER_B: begin
        q_row   = SZ'(top_q) - SZ'(1);
        q_col   = SZ'(right_q);
        rd_zero = (top_q == '0);
      end
      sat_pkg::CORNER_C: begin
        q_row   = SZ'(bottom_q);
        q_col   = SZ'(left_q) - SZ'(1);
        rd_zero = (left_q == '0);
      end
      default: begin
        q_row   = SZ'(top_q) - SZ'(1);
        q_col   = SZ'(left_q) - SZ'(1);
        rd_zero = (top_q == '0) || (left_q == '0);
      end
    endcase
  end

  // Read port: the entry above during a load, a corner during a query.
  always_comb begin
    if (cmd_i.ld_read) begin
      rd_addr = tab_addr(SZ'(load_row_q) - SZ'(1), SZ'(load_col_q));
      rd_en   = (load_row_q != '0);
    end else begin
      rd_addr = tab_addr(q_row, q_col);
      rd_en   = cmd_i.q_read && !rd_zero;
    end
  end

  // Write port: running row sum plus the entry above.
  assign wr_addr = tab_addr(SZ'(load_row_q), SZ'(load_col_q));
  assign wr_data = row_sum_q + ((load_row_q == '0) ? '0 : rd_data);

  sat_ram #(
    .WIDTH(SW),
    .DEPTH(Depth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ld_write),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // Inclusion-exclusion accumulation of the returned corner.
  always_comb begin
    unique case (cmd_i.acc_corner)
      sat_pkg::CORNER_B: acc_zero = (top_q == '0);
      sat_pkg::CORNER_C: acc_zero = (left_q == '0);
      sat_pkg::CORNER_D: acc_zero = (top_q == '0) || (left_q == '0);
      default:           acc_zero = 1'b0;
    endcase
    acc_val = acc_zero ? '0 : rd_data;
    acc_d   = acc_q;
    if (cmd_i.acc_en) begin
      unique case (cmd_i.acc_corner)
        sat_pkg::CORNER_A: acc_d = acc_val;
        sat_pkg::CORNER_B: acc_d = acc_q - acc_val;
        sat_pkg::CORNER_C: acc_d = acc_q - acc_val;
        default:           acc_d = acc_q + acc_val;
      endcase
    end
  end

  // Size registers and load bookkeeping.
  always_comb begin
    rows_d     = rows_q;
    cols_d     = cols_q;
    load_row_d = load_row_q;
    load_col_d = load_col_q;
    row_sum_d  = row_sum_q;
    ready_d    = ready_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == sat_pkg::CFG_ROWS) begin
        rows_d = cfg_data_i;
      end else begin
        cols_d = cfg_data_i;
      end
      load_row_d = '0;
      load_col_d = '0;
      row_sum_d  = '0;
      ready_d    = 1'b0;
    end else if (cmd_i.accept_load && ready_q) begin
      // A load after a complete table starts a new matrix.
      load_row_d = '0;
      load_col_d = '0;
      row_sum_d  = '0;
      ready_d    = 1'b0;
    end else if (cmd_i.ld_read) begin
      row_sum_d = row_sum_q + elem_ext;
    end else if (cmd_i.ld_write) begin
      if (col_last) begin
        load_col_d = '0;
        row_sum_d  = '0;
        if (row_last) begin
          load_row_d = '0;
          ready_d    = 1'b1;
        end else begin
          load_row_d = load_row_q + RowIdxW'(1);
        end
      end else begin
        load_col_d = load_col_q + ColIdxW'(1);
      end
    end
  end

  // Output register: filled on push, emptied when taken.
  always_comb begin
    if (cmd_i.out_push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= sat_pkg::SIZE_RESET;
      cols_q      <= sat_pkg::SIZE_RESET;
      load_row_q  <= '0;
      load_col_q  <= '0;
      row_sum_q   <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      load_row_q  <= load_row_d;
      load_col_q  <= load_col_d;
      row_sum_q   <= row_sum_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_load) begin
      elem_q <= element_value_i;
    end
    if (cmd_i.accept_query) begin
      top_q    <= top_row_i;
      left_q   <= left_col_i;
      bottom_q <= bottom_row_i;
      right_q  <= right_col_i;
      status_q <= status_d;
    end
    acc_q <= acc_d;
    if (cmd_i.out_push) begin
      out_sum_q    <= (status_q == sat_pkg::ST_OK) ? acc_d : '0;
      out_status_q <= status_q;
    end
  end

  assign dp_status_o.query_err = (status_q != sat_pkg::ST_OK);
  assign dp_status_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign region_sum_o    = out_sum_q;
  assign result_status_o = out_status_q;

endmodule

// ----- rtl/sat_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_ctrl: controller of the summed-area table core
// Sequences the read and write of a load and the four corner reads of a
// query, and hands finished results to the output register.
// ----------------------------------------------------------------------------
module sat_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                operation_i,
  input  sat_pkg::dp_status_t dp_status_i,
  output sat_pkg::cmd_t       cmd_o
);

  sat_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sat_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d            = state_q;
    cmd_o.in_stall     = (state_q != sat_pkg::S_IDLE);
    cmd_o.accept_load  = 1'b0;
    cmd_o.accept_query = 1'b0;
    cmd_o.ld_read      = 1'b0;
    cmd_o.ld_write     = 1'b0;
    cmd_o.q_read       = 1'b0;
    cmd_o.rd_corner    = sat_pkg::CORNER_A;
    cmd_o.acc_en       = 1'b0;
    cmd_o.acc_corner   = sat_pkg::CORNER_A;
    cmd_o.out_push     = 1'b0;
    unique case (state_q)
      sat_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (sat_pkg::op_e'(operation_i) == sat_pkg::OP_LOAD) begin
            cmd_o.accept_load = 1'b1;
            state_d           = sat_pkg::S_LD_RD;
          end else begin
            cmd_o.accept_query = 1'b1;
            state_d            = sat_pkg::S_Q0;
          end
        end
      end
      sat_pkg::S_LD_RD: begin
        cmd_o.ld_read = 1'b1;
        state_d       = sat_pkg::S_LD_WR;
      end
      sat_pkg::S_LD_WR: begin
        cmd_o.ld_write = 1'b1;
        state_d        = sat_pkg::S_IDLE;
      end
      sat_pkg::S_Q0: begin
        if (dp_status_i.query_err) begin
          // Flagged query: report without reading the table, waiting in S_HOLD while the output register is busy.
          if (!dp_status_i.out_busy) begin
            cmd_o.out_push = 1'b1;
            state_d        = sat_pkg::S_IDLE;
          end else begin
            state_d = sat_pkg::S_HOLD;
          end
        end else begin
          cmd_o.q_read    = 1'b1;
          cmd_o.rd_corner = sat_pkg::CORNER_A;
          state_d         = sat_pkg::S_Q1;
        end
      end
      sat_pkg::S_Q1: begin
        cmd_o.acc_en     = 1'b1;
        cmd_o.acc_corner = sat_pkg::CORNER_A;
        cmd_o.q_read     = 1'b1;
        cmd_o.rd_corner  = sat_pkg::CORNER_B;
        state_d          = sat_pkg::S_Q2;
      end
      sat_pkg::S_Q2: begin
        cmd_o.acc_en     = 1'b1;
        cmd_o.acc_corner = sat_pkg::CORNER_B;
        cmd_o.q_read     = 1'b1;
        cmd_o.rd_corner  = sat_pkg::CORNER_C;
        state_d          = sat_pkg::S_Q3;
      end
      sat_pkg::S_Q3: begin
        cmd_o.acc_en     = 1'b1;
        cmd_o.acc_corner = sat_pkg::CORNER_C;
        cmd_o.q_read     = 1'b1;
        cmd_o.rd_corner  = sat_pkg::CORNER_D;
        state_d          = sat_pkg::S_Q4;
      end
      sat_pkg::S_Q4: begin
        cmd_o.acc_en     = 1'b1;
        cmd_o.acc_corner = sat_pkg::CORNER_D;
        if (!dp_status_i.out_busy) begin
          cmd_o.out_push = 1'b1;
          state_d        = sat_pkg::S_IDLE;
        end else begin
          state_d = sat_pkg::S_HOLD;
        end
      end
      sat_pkg::S_HOLD: begin
        // Wait for the output register to free up.
        if (!dp_status_i.out_busy) begin
          cmd_o.out_push = 1'b1;
          state_d        = sat_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sat_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/summed_area_table_region_sum_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// summed_area_table_region_sum_core: integral image with region-sum queries
// Top level joining the controller, the datapath and the table memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): an item is a load (operation 0)
//   carrying one matrix element in raster order, or a query (operation 1)
//   naming an inclusive rectangle. Loads give no result; each query gives
//   one result on the output channel (out_valid_o / out_stall_i) with the
//   region sum and a status code (ok, bad rectangle, table not loaded).
//   A load reads the entry above, then writes the new entry. A query reads
//   its four corners one after another through the table RAM's single read
//   port, then puts its result in the output register; a flagged query skips
//   the reads. No new item is taken until the current one is done.
//   The configuration port (cfg_valid_i / cfg_ready_o) is always ready and
//   sets the row and column counts; any write restarts loading.
//   Reset sets both sizes to 256 and marks the table as not loaded; the
//   table RAM is not cleared. While the receiver stalls, the result holds
//   in the output register and the next item is still taken; a query that
//   finishes while that register is full waits for it to drain.
// ----------------------------------------------------------------------------
module summed_area_table_region_sum_core #(
  parameter int unsigned MAX_ROWS = sat_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = sat_pkg::MAX_COLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sat_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sat_pkg::SIZE_W-1:0]         cfg_data_i,
  // Input item channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic signed [sat_pkg::ELEM_W-1:0]  element_value_i,
  input  logic [sat_pkg::COORD_W-1:0]        top_row_i,
  input  logic [sat_pkg::COORD_W-1:0]        left_col_i,
  input  logic [sat_pkg::COORD_W-1:0]        bottom_row_i,
  input  logic [sat_pkg::COORD_W-1:0]        right_col_i,
  // Result item channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [sat_pkg::SUM_W-1:0]   region_sum_o,
  output logic [1:0]                         status_o
);

  sat_pkg::cmd_t       cmd;
  sat_pkg::dp_status_t dp_status;

  // Size registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = cmd.in_stall;

  sat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .operation_i(operation_i),
    .dp_status_i(dp_status),
    .cmd_o      (cmd)
  );

  sat_datapath #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .element_value_i(element_value_i),
    .top_row_i      (top_row_i),
    .left_col_i     (left_col_i),
    .bottom_row_i   (bottom_row_i),
    .right_col_i    (right_col_i),
    .cmd_i          (cmd),
    .dp_status_o    (dp_status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .region_sum_o   (region_sum_o),
    .result_status_o(status_o)
  );

  // A flagged result always carries a zero sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != sat_pkg::ST_OK)) |-> (region_sum_o == '0))
    else $error("flagged result with nonzero sum");

  // An accepted item always occupies the block for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepting an item");

  // A load item never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !operation_i) |=> !$rose(out_valid_o))
    else $error("result raised after a load item");

endmodule
